>>> rtl/esgcv_pkg.sv
package esgcv_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_MODE      = 3'd0,
    CFG_ROW_ONE        = 3'd1,
    CFG_ROW_TWO        = 3'd2,
    CFG_ROW_THREE      = 3'd3,
    CFG_PULSE_TICKS    = 3'd4,
    CFG_TRIGGER_HIGH   = 3'd5,
    CFG_TRIGGER_LOW    = 3'd6
  } cfg_idx_e;

  // gate mode codes; any other code acts as continuous
  localparam logic [1:0] GATE_TRIGGER    = 2'd0;
  localparam logic [1:0] GATE_RETRIGGER  = 2'd1;
  localparam logic [1:0] GATE_CONTINUOUS = 2'd2;

  localparam logic [1:0]         GATE_MODE_RST    = GATE_TRIGGER;
  localparam logic [15:0]        PULSE_TICKS_RST  = 16'd44;
  localparam logic signed [11:0] TRIGGER_HIGH_RST = 12'sd205;
  localparam logic signed [11:0] TRIGGER_LOW_RST  = 12'sd0;

  typedef struct packed {
    logic [1:0]         gate_mode;
    logic [63:0]        row_one_levels;
    logic [63:0]        row_two_levels;
    logic [63:0]        row_three_levels;
    logic [15:0]        pulse_ticks;
    logic signed [11:0] trigger_high;
    logic signed [11:0] trigger_low;
  } cfg_t;

  typedef struct packed {
    logic               run_button;
    logic signed [11:0] start_level;
    logic signed [11:0] stop_level;
    logic               ext_clock_present;
    logic signed [11:0] ext_clock_level;
    logic [23:0]        phase_increment;
    logic signed [11:0] reset_level;
    logic [3:0]         steps_requested;
    logic [7:0]         gate_buttons;
  } in_item_t;

  typedef struct packed {
    logic       clock_pulse;
    logic       step_gate_active;
    logic [7:0] gate_lines;
    logic [2:0] current_step;
    logic [7:0] row_one_out;
    logic [7:0] row_two_out;
    logic [7:0] row_three_out;
    logic       is_running;
    logic [7:0] gate_enable_bits;
  } res_t;

  // Hysteresis detector: returns {next high state, fired}
  function automatic logic [1:0] schmitt(logic hi, logic signed [11:0] x,
                                         logic signed [11:0] th,
                                         logic signed [11:0] tl);
    logic [1:0] r;
    r = {hi, 1'b0};
    if (!hi) begin
      if (x >= th) r = 2'b11;
    end else if (x <= tl) begin
      r = 2'b00;
    end
    return r;
  endfunction

endpackage

>>> rtl/esgcv_cfg.sv
module esgcv_cfg
  import esgcv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_mode        <= GATE_MODE_RST;
      cfg_q.row_one_levels   <= '0;
      cfg_q.row_two_levels   <= '0;
      cfg_q.row_three_levels <= '0;
      cfg_q.pulse_ticks      <= PULSE_TICKS_RST;
      cfg_q.trigger_high     <= TRIGGER_HIGH_RST;
      cfg_q.trigger_low      <= TRIGGER_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GATE_MODE:    cfg_q.gate_mode        <= cfg_wdata_i[1:0];
        CFG_ROW_ONE:      cfg_q.row_one_levels   <= cfg_wdata_i;
        CFG_ROW_TWO:      cfg_q.row_two_levels   <= cfg_wdata_i;
        CFG_ROW_THREE:    cfg_q.row_three_levels <= cfg_wdata_i;
        CFG_PULSE_TICKS:  cfg_q.pulse_ticks      <= cfg_wdata_i[15:0];
        CFG_TRIGGER_HIGH: cfg_q.trigger_high     <= cfg_wdata_i[11:0];
        CFG_TRIGGER_LOW:  cfg_q.trigger_low      <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/esgcv_core.sv
module esgcv_core
  import esgcv_pkg::*;
#(
  parameter int unsigned NUM_STEPS  = 8,
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned LEVEL_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output res_t     res_o
);

  localparam int unsigned IDX_W = $clog2(NUM_STEPS);
  localparam int unsigned CNT_W = $clog2(NUM_STEPS + 1);
  localparam logic [63:0] LVL_MASK = (64'd1 << LEVEL_BITS) - 64'd1;

  logic                  running_q, running_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [IDX_W-1:0]      step_q, step_d;
  logic [7:0]            gate_en_q, gate_en_d;
  logic [15:0]           pulse_cnt_q, pulse_cnt_d;
  logic                  run_det_q, run_det_d;
  logic                  rst_det_q, rst_det_d;
  logic                  clk_det_q, clk_det_d;
  logic [7:0]            gate_det_q, gate_det_d;

  logic [PHASE_BITS-1:0] inc;
  logic [PHASE_BITS:0]   phase_sum;
  logic [1:0]            clk_sch, rst_sch;
  logic                  clk_adv, advance, pulse, gate_on;
  logic [4:0]            req;
  logic [CNT_W-1:0]      nsteps, step_inc;
  logic [15:0]           pulse_cnt;
  logic [2:0]            step_lo;
  res_t                  res_d, res_q;

  function automatic logic [7:0] level_of(logic [63:0] r, logic [IDX_W-1:0] idx);
    int unsigned sh;
    logic [63:0] t;
    sh = 32'(idx) * LEVEL_BITS;
    t  = r >> sh;
    if (sh >= 32'd64) return 8'd0;
    return 8'(t & LVL_MASK);
  endfunction

  // Scale the 0.24 increment to the accumulator width
  if (PHASE_BITS >= 24) begin : g_inc_up
    assign inc = PHASE_BITS'(item_i.phase_increment) << (PHASE_BITS - 24);
  end else begin : g_inc_dn
    assign inc = PHASE_BITS'(item_i.phase_increment >> (24 - PHASE_BITS));
  end

  assign phase_sum = {1'b0, phase_q} + {1'b0, inc};
  assign clk_sch   = schmitt(clk_det_q, item_i.ext_clock_level,
                             cfg_i.trigger_high, cfg_i.trigger_low);
  assign rst_sch   = schmitt(rst_det_q, item_i.reset_level,
                             cfg_i.trigger_high, cfg_i.trigger_low);
  assign req       = {1'b0, item_i.steps_requested};
  assign step_inc  = CNT_W'(step_q) + CNT_W'(1);

  always_comb begin
    // run control: toggle, then start, then stop
    run_det_d = item_i.run_button;
    running_d = running_q ^ (item_i.run_button & ~run_det_q);
    if (item_i.start_level > 12'sd0) running_d = 1'b1;
    if (item_i.stop_level > 12'sd0)  running_d = 1'b0;

    // clock source
    clk_adv   = 1'b0;
    phase_d   = phase_q;
    clk_det_d = clk_det_q;
    if (running_d) begin
      if (item_i.ext_clock_present) begin
        clk_det_d = clk_sch[1];
        if (clk_sch[0]) begin
          phase_d = '0;
          clk_adv = 1'b1;
        end
      end else begin
        phase_d = phase_sum[PHASE_BITS-1:0];
        clk_adv = phase_sum[PHASE_BITS];
      end
    end

    // step advance with clamped count
    if (req == 5'd0)                nsteps = CNT_W'(1);
    else if (req > 5'(NUM_STEPS))   nsteps = CNT_W'(NUM_STEPS);
    else                            nsteps = CNT_W'(req);
    step_d = step_q;
    if (clk_adv) step_d = (step_inc >= nsteps) ? '0 : IDX_W'(step_inc);

    // reset edge overrides the advance
    advance   = clk_adv;
    rst_det_d = rst_sch[1];
    if (rst_sch[0]) begin
      phase_d = '0;
      step_d  = '0;
      advance = 1'b1;
    end

    pulse_cnt   = advance ? cfg_i.pulse_ticks : pulse_cnt_q;
    pulse       = (pulse_cnt != 16'd0);
    pulse_cnt_d = pulse ? pulse_cnt - 16'd1 : 16'd0;

    gate_det_d = item_i.gate_buttons;
    gate_en_d  = gate_en_q ^ (item_i.gate_buttons & ~gate_det_q);

    step_lo = 3'(step_d);
    gate_on = running_d && (32'(step_d) < 32'd8) && gate_en_d[step_lo];
    case (cfg_i.gate_mode)
      GATE_TRIGGER:   gate_on = gate_on & pulse;
      GATE_RETRIGGER: gate_on = gate_on & ~pulse;
      default: ;
    endcase

    res_d.clock_pulse      = clk_adv;
    res_d.step_gate_active = gate_on;
    res_d.gate_lines       = gate_on ? (8'd1 << step_lo) : 8'd0;
    res_d.current_step     = step_lo;
    res_d.row_one_out      = level_of(cfg_i.row_one_levels, step_d);
    res_d.row_two_out      = level_of(cfg_i.row_two_levels, step_d);
    res_d.row_three_out    = level_of(cfg_i.row_three_levels, step_d);
    res_d.is_running       = running_d;
    res_d.gate_enable_bits = gate_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b1;
      phase_q     <= '0;
      step_q      <= '0;
      gate_en_q   <= '0;
      pulse_cnt_q <= '0;
      run_det_q   <= 1'b0;
      rst_det_q   <= 1'b0;
      clk_det_q   <= 1'b0;
      gate_det_q  <= '0;
    end else if (take_i) begin
      running_q   <= running_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      gate_en_q   <= gate_en_d;
      pulse_cnt_q <= pulse_cnt_d;
      run_det_q   <= run_det_d;
      rst_det_q   <= rst_det_d;
      clk_det_q   <= clk_det_d;
      gate_det_q  <= gate_det_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/eight_step_gate_cv_sequencer.sv
// Eight-step gate and CV sequencer. Feed one item per sample tick; each
// item yields exactly one result item carrying the current step, its three
// row levels, the filtered step gate, the one-hot gate lines, the run flag
// and the stored gate enables. An item passes an input register, one
// combinational pass over the sequencer state, and a result register; the
// rate is one item per clock while the result side does not stall, set by
// that single pass. A stall on the result side holds the result register
// and, while it holds an item, the input register. Configuration registers
// are written through a plain write port (no read-back); the user must
// write them only while the block is idle; the block does not enforce it.
// After reset the sequence runs at step 0 with all gate enables off, gate
// mode trigger, a 44-tick pulse and detector thresholds 205 high, 0 low.
module eight_step_gate_cv_sequencer
  import esgcv_pkg::*;
#(
  parameter int unsigned NUM_STEPS  = 8,
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned LEVEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  run_button_i,
  input  logic signed [11:0]    start_level_i,
  input  logic signed [11:0]    stop_level_i,
  input  logic                  ext_clock_present_i,
  input  logic signed [11:0]    ext_clock_level_i,
  input  logic [23:0]           phase_increment_i,
  input  logic signed [11:0]    reset_level_i,
  input  logic [3:0]            steps_requested_i,
  input  logic [7:0]            gate_buttons_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  clock_pulse_o,
  output logic                  step_gate_active_o,
  output logic [7:0]            gate_lines_o,
  output logic [2:0]            current_step_o,
  output logic [7:0]            row_one_out_o,
  output logic [7:0]            row_two_out_o,
  output logic [7:0]            row_three_out_o,
  output logic                  is_running_o,
  output logic [7:0]            gate_enable_bits_o
);

  cfg_t     cfg;
  in_item_t item_q;
  res_t     res;
  logic     in_valid_q;
  logic     out_valid_q, out_valid_d;
  logic     res_ready;
  logic     take;

  esgcv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Result register is free when empty or being drained this cycle
  assign res_ready  = ~out_valid_q | ~out_stall_i;
  // Move the held item through the sequencer pass into the result register
  assign take       = in_valid_q & res_ready;
  // Hold the input register while its item cannot move on
  assign in_stall_o = in_valid_q & ~take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the item payload only on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.run_button        <= run_button_i;
      item_q.start_level       <= start_level_i;
      item_q.stop_level        <= stop_level_i;
      item_q.ext_clock_present <= ext_clock_present_i;
      item_q.ext_clock_level   <= ext_clock_level_i;
      item_q.phase_increment   <= phase_increment_i;
      item_q.reset_level       <= reset_level_i;
      item_q.steps_requested   <= steps_requested_i;
      item_q.gate_buttons      <= gate_buttons_i;
    end
  end

  esgcv_core #(
    .NUM_STEPS  (NUM_STEPS),
    .PHASE_BITS (PHASE_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result valid: set on a new result, drop once taken downstream
  always_comb begin
    out_valid_d = out_valid_q;
    if (take)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign clock_pulse_o      = res.clock_pulse;
  assign step_gate_active_o = res.step_gate_active;
  assign gate_lines_o       = res.gate_lines;
  assign current_step_o     = res.current_step;
  assign row_one_out_o      = res.row_one_out;
  assign row_two_out_o      = res.row_two_out;
  assign row_three_out_o    = res.row_three_out;
  assign is_running_o       = res.is_running;
  assign gate_enable_bits_o = res.gate_enable_bits;

endmodule

>>> rtl/esgcv_checker.sv
module esgcv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       step_gate_active_o,
  input logic [7:0] gate_lines_o,
  input logic [2:0] current_step_o,
  input logic       is_running_o
);

  // at most one gate line, and only when the step gate is on
  a_lines_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(gate_lines_o) &&
                    ((gate_lines_o != 8'd0) == step_gate_active_o))
    else $error("gate lines disagree with step gate");

  // the active line sits at the current step
  a_line_at_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && step_gate_active_o) |-> gate_lines_o == (8'd1 << current_step_o))
    else $error("gate line not at current step");

  // a stopped sequencer drives no gate
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_running_o) |-> !step_gate_active_o)
    else $error("gate active while stopped");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(gate_lines_o) &&
                                     $stable(current_step_o))
    else $error("stalled result changed");

endmodule

bind eight_step_gate_cv_sequencer esgcv_checker u_esgcv_checker (.*);
